>>> src/signalling_link_test_supervisor_macros.svh
// ----------------------------------------------------------------------------
// Signalling link test supervisor assertion macros
// Shared forms for the concurrent checks of the supervisor.
// ----------------------------------------------------------------------------
`ifndef SIGNALLING_LINK_TEST_SUPERVISOR_MACROS_SVH
`define SIGNALLING_LINK_TEST_SUPERVISOR_MACROS_SVH

// Same-cycle implication, held off during reset
`define SLTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slts: same-cycle check failed");

// Next-cycle implication, held off during reset
`define SLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slts: next-cycle check failed");

`endif

>>> src/slts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signalling link test supervisor package
// Field widths, command and status codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package slts_pkg;

    localparam int CMD_W       = 3;
    localparam int INFO_LEN_W  = 8;
    localparam int TOTAL_LEN_W = 16;
    localparam int HEAD_W      = 64;
    localparam int TAIL_W      = 48;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 2;

    localparam int TIMER_WIDTH_DEF = 20;

    // Expected answer: "GSMMMS" followed by eight zero bytes
    localparam logic [HEAD_W-1:0]      PATTERN_HEAD      = 64'h4753_4D4D_4D53_0000;
    localparam logic [TAIL_W-1:0]      PATTERN_TAIL      = 48'h0;
    localparam logic [INFO_LEN_W-1:0]  GOOD_INFO_LENGTH  = 8'd14;
    localparam logic [TOTAL_LEN_W-1:0] GOOD_TOTAL_LENGTH = 16'd16;

    // Register reset values
    localparam logic [CFG_W-1:0] RESPONSE_TICKS_RST = 20'd10000;
    localparam logic [CFG_W-1:0] REPEAT_TICKS_RST   = 20'd60000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_ANSWER  = 3'd3,
        CMD_BLOCK   = 3'd4,
        CMD_UNBLOCK = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE          = 3'd0,
        ST_ACCEPTED      = 3'd1,
        ST_BAD_INFO_LEN  = 3'd2,
        ST_BAD_TOTAL_LEN = 3'd3,
        ST_BAD_PATTERN   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESPONSE_TICKS = 2'd0,
        REG_REPEAT_TICKS   = 2'd1,
        REG_SEND_ONCE      = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] response_ticks;
        logic [CFG_W-1:0] repeat_ticks;
        logic             send_once;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [INFO_LEN_W-1:0]  answer_info_length;
        logic [TOTAL_LEN_W-1:0] answer_total_length;
        logic [HEAD_W-1:0]      pattern_head;
        logic [TAIL_W-1:0]      pattern_tail;
        logic                   linkset_running;
    } t_item;

    typedef struct packed {
        logic                send_test;
        logic                request_reset;
        logic                request_shutdown;
        logic [STATUS_W-1:0] answer_status;
        logic                timeout_event;
        logic                error_event;
        logic                test_pending;
    } t_result;

endpackage

>>> src/slts_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor command channel
// Valid/ready channel carrying one command item with its answer fields.
// ----------------------------------------------------------------------------
interface slts_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [slts_pkg::CMD_W-1:0]         cmd;
    logic [slts_pkg::INFO_LEN_W-1:0]    answer_info_length;
    logic [slts_pkg::TOTAL_LEN_W-1:0]   answer_total_length;
    logic [slts_pkg::HEAD_W-1:0]        pattern_head;
    logic [slts_pkg::TAIL_W-1:0]        pattern_tail;
    logic                               linkset_running;

    modport source (
        output valid, cmd, answer_info_length, answer_total_length,
               pattern_head, pattern_tail, linkset_running,
        input  ready
    );

    modport sink (
        input  valid, cmd, answer_info_length, answer_total_length,
               pattern_head, pattern_tail, linkset_running,
        output ready
    );
endinterface

>>> src/slts_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor result channel
// Valid/ready channel carrying one result item per command.
// ----------------------------------------------------------------------------
interface slts_res_if;
    logic                            valid;
    logic                            ready;
    logic                            send_test;
    logic                            request_reset;
    logic                            request_shutdown;
    logic [slts_pkg::STATUS_W-1:0]   answer_status;
    logic                            timeout_event;
    logic                            error_event;
    logic                            test_pending;

    modport source (
        output valid, send_test, request_reset, request_shutdown,
               answer_status, timeout_event, error_event, test_pending,
        input  ready
    );

    modport sink (
        input  valid, send_test, request_reset, request_shutdown,
               answer_status, timeout_event, error_event, test_pending,
        output ready
    );
endinterface

>>> src/slts_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor configuration registers
// Write-only timer and mode registers, loaded through a plain write port.
// ----------------------------------------------------------------------------
module slts_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [slts_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [slts_pkg::CFG_W-1:0]       i_wdata,
    output slts_pkg::t_cfg                   o_cfg
);

    slts_pkg::t_cfg r_cfg;

    // Load the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.response_ticks <= slts_pkg::RESPONSE_TICKS_RST;
            r_cfg.repeat_ticks   <= slts_pkg::REPEAT_TICKS_RST;
            r_cfg.send_once      <= 1'b0;
        end else if (i_we) begin
            unique case (i_idx)
                slts_pkg::REG_RESPONSE_TICKS: r_cfg.response_ticks <= i_wdata;
                slts_pkg::REG_REPEAT_TICKS:   r_cfg.repeat_ticks   <= i_wdata;
                slts_pkg::REG_SEND_ONCE:      r_cfg.send_once      <= i_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/slts_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor engine
// Link test state with timers, and the single-pass update for one item.
// ----------------------------------------------------------------------------
module slts_engine #(
    parameter int TIMER_WIDTH = slts_pkg::TIMER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  slts_pkg::t_item   i_item,
    input  slts_pkg::t_cfg    i_cfg,
    output slts_pkg::t_result o_result
);

    localparam int LOAD_W = (TIMER_WIDTH > slts_pkg::CFG_W) ? TIMER_WIDTH : slts_pkg::CFG_W;
    localparam logic [LOAD_W-1:0] TIMER_MAX = LOAD_W'({TIMER_WIDTH{1'b1}});
    localparam logic [TIMER_WIDTH-1:0] ONE_TICK = TIMER_WIDTH'(1);

    logic [TIMER_WIDTH-1:0] r_response_left, n_response_left;
    logic                   r_response_armed, n_response_armed;
    logic [TIMER_WIDTH-1:0] r_repeat_left, n_repeat_left;
    logic                   r_repeat_armed, n_repeat_armed;
    logic                   r_missed_once, n_missed_once;
    logic                   r_pending_flag, n_pending_flag;
    logic                   r_seen_up, n_seen_up;
    logic                   r_blocked_flag, n_blocked_flag;

    logic [LOAD_W-1:0]      w_resp_ext;
    logic [LOAD_W-1:0]      w_rep_ext;
    logic [TIMER_WIDTH-1:0] w_resp_load;
    logic [TIMER_WIDTH-1:0] w_rep_load;
    logic                   w_begin;
    slts_pkg::t_result      w_res;

    // Saturate the register values to the timer width
    assign w_resp_ext  = LOAD_W'(i_cfg.response_ticks);
    assign w_rep_ext   = LOAD_W'(i_cfg.repeat_ticks);
    assign w_resp_load = (w_resp_ext > TIMER_MAX) ? TIMER_WIDTH'(TIMER_MAX)
                                                  : TIMER_WIDTH'(w_resp_ext);
    assign w_rep_load  = (w_rep_ext > TIMER_MAX) ? TIMER_WIDTH'(TIMER_MAX)
                                                 : TIMER_WIDTH'(w_rep_ext);

    // Next state and result for the item at the input register
    always_comb begin
        n_response_left  = r_response_left;
        n_response_armed = r_response_armed;
        n_repeat_left    = r_repeat_left;
        n_repeat_armed   = r_repeat_armed;
        n_missed_once    = r_missed_once;
        n_pending_flag   = r_pending_flag;
        n_seen_up        = r_seen_up;
        n_blocked_flag   = r_blocked_flag;
        w_begin          = 1'b0;
        w_res            = '0;

        unique case (i_item.cmd)
            slts_pkg::CMD_TICK: begin
                // Response timer first
                if (r_response_armed) begin
                    if (r_response_left <= ONE_TICK) begin
                        n_response_armed    = 1'b0;
                        n_response_left     = '0;
                        w_res.timeout_event = 1'b1;
                        if (!r_missed_once) begin
                            n_missed_once    = 1'b1;
                            n_pending_flag   = 1'b1;
                            w_res.send_test  = 1'b1;
                            n_response_armed = 1'b1;
                            n_response_left  = w_resp_load;
                        end else begin
                            n_repeat_armed = 1'b0;
                            n_repeat_left  = '0;
                            if (!r_blocked_flag) begin
                                w_res.error_event   = 1'b1;
                                w_res.request_reset = 1'b1;
                            end
                        end
                    end else begin
                        n_response_left = r_response_left - ONE_TICK;
                    end
                end
                // Then the repeat timer, as left by a second miss
                if (n_repeat_armed) begin
                    if (n_repeat_left <= ONE_TICK) begin
                        n_repeat_armed = 1'b0;
                        n_repeat_left  = '0;
                        w_begin        = 1'b1;
                    end else begin
                        n_repeat_left = n_repeat_left - ONE_TICK;
                    end
                end
            end
            slts_pkg::CMD_START: begin
                w_begin = 1'b1;
            end
            slts_pkg::CMD_STOP: begin
                n_response_armed = 1'b0;
                n_response_left  = '0;
                n_repeat_armed   = 1'b0;
                n_repeat_left    = '0;
                n_pending_flag   = 1'b0;
            end
            slts_pkg::CMD_ANSWER: begin
                if (i_item.answer_info_length != slts_pkg::GOOD_INFO_LENGTH) begin
                    w_res.answer_status = slts_pkg::ST_BAD_INFO_LEN;
                end else if (i_item.answer_total_length != slts_pkg::GOOD_TOTAL_LENGTH) begin
                    w_res.answer_status = slts_pkg::ST_BAD_TOTAL_LEN;
                end else if (i_item.pattern_head != slts_pkg::PATTERN_HEAD ||
                             i_item.pattern_tail != slts_pkg::PATTERN_TAIL) begin
                    w_res.answer_status = slts_pkg::ST_BAD_PATTERN;
                end else begin
                    w_res.answer_status = slts_pkg::ST_ACCEPTED;
                    n_response_armed    = 1'b0;
                    n_response_left     = '0;
                    n_pending_flag      = 1'b0;
                    n_seen_up           = 1'b1;
                end
            end
            slts_pkg::CMD_BLOCK: begin
                n_blocked_flag         = 1'b1;
                w_res.request_shutdown = 1'b1;
            end
            slts_pkg::CMD_UNBLOCK: begin
                if (r_blocked_flag) begin
                    n_blocked_flag      = 1'b0;
                    w_res.request_reset = 1'b1;
                end
            end
            default: ;
        endcase

        // Start a test round, only while the linkset runs
        if (w_begin && i_item.linkset_running) begin
            n_missed_once    = 1'b0;
            n_pending_flag   = 1'b1;
            n_response_armed = 1'b1;
            n_response_left  = w_resp_load;
            w_res.send_test  = 1'b1;
            if (i_cfg.send_once && r_seen_up) begin
                n_repeat_armed = 1'b0;
                n_repeat_left  = '0;
            end else begin
                n_repeat_armed = 1'b1;
                n_repeat_left  = w_rep_load;
            end
        end

        w_res.test_pending = n_pending_flag;
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_left  <= '0;
            r_response_armed <= 1'b0;
            r_repeat_left    <= '0;
            r_repeat_armed   <= 1'b0;
            r_missed_once    <= 1'b0;
            r_pending_flag   <= 1'b0;
            r_seen_up        <= 1'b0;
            r_blocked_flag   <= 1'b0;
        end else if (i_adv) begin
            r_response_left  <= n_response_left;
            r_response_armed <= n_response_armed;
            r_repeat_left    <= n_repeat_left;
            r_repeat_armed   <= n_repeat_armed;
            r_missed_once    <= n_missed_once;
            r_pending_flag   <= n_pending_flag;
            r_seen_up        <= n_seen_up;
            r_blocked_flag   <= n_blocked_flag;
        end
    end

    assign o_result = w_res;

endmodule

>>> src/signalling_link_test_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signalling link test supervisor
// Runs the link test timers and answer checks, one result item per command.
// ----------------------------------------------------------------------------
// The supervisor takes one command item per clock while results are taken,
// and returns exactly one result item for it. An accepted item sits in an
// input register while the timer, answer and block logic computes its result
// and the next state in a single pass; the result is registered into the
// output register, where it waits until taken. The sustained rate is one item
// per cycle, limited only by result back-pressure.
// Configuration writes take effect on the next item and are meant for idle
// periods.
module signalling_link_test_supervisor #(
    parameter int TIMER_WIDTH = slts_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [slts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [slts_pkg::CFG_W-1:0]       i_cfg_wdata,
    slts_cmd_if.sink                         i_cmd,
    slts_res_if.source                       o_res
);

`include "signalling_link_test_supervisor_macros.svh"

    slts_pkg::t_cfg    w_cfg;
    slts_pkg::t_item   r_in;
    logic              r_in_valid;
    slts_pkg::t_result w_result;
    slts_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_adv;
    logic              w_in_ready;

    slts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // Move an item forward when the result register is free or being taken
    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_cmd.ready = w_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_cmd.valid) begin
            r_in.cmd                 <= i_cmd.cmd;
            r_in.answer_info_length  <= i_cmd.answer_info_length;
            r_in.answer_total_length <= i_cmd.answer_total_length;
            r_in.pattern_head        <= i_cmd.pattern_head;
            r_in.pattern_tail        <= i_cmd.pattern_tail;
            r_in.linkset_running     <= i_cmd.linkset_running;
        end
    end

    slts_engine #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.send_test        = r_out.send_test;
    assign o_res.request_reset    = r_out.request_reset;
    assign o_res.request_shutdown = r_out.request_shutdown;
    assign o_res.answer_status    = r_out.answer_status;
    assign o_res.timeout_event    = r_out.timeout_event;
    assign o_res.error_event      = r_out.error_event;
    assign o_res.test_pending     = r_out.test_pending;

    // A counted failure is always a timeout that asks for a reset
    `SLTS_ASSERT_IMPLY(a_error_is_timeout, i_clk, i_rst_n, o_res.valid && o_res.error_event, o_res.timeout_event && o_res.request_reset)
    // An accepted answer clears the pending test
    `SLTS_ASSERT_IMPLY(a_accept_clears_pending, i_clk, i_rst_n, o_res.valid && o_res.answer_status == slts_pkg::ST_ACCEPTED, !o_res.test_pending)
    // A stalled input item stays in its register
    `SLTS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    // An advancing item always lands in the result register
    `SLTS_ASSERT_NEXT(a_adv_lands, i_clk, i_rst_n, w_adv, r_out_valid)

endmodule
